// ----- rtl/rtcq_pkg.sv -----
package rtcq_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned OUT_TAG_W = 16;
  localparam int unsigned STATUS_W  = 2;

  localparam logic MODE_STORE   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE_DUE = 2'd3;

  // Per-cell control, shared by the whole row except the position flags
  typedef struct packed {
    logic ins;
    logic pop;
    logic occupied;
    logic at_tail;
  } cell_ctrl_t;

endpackage

// ----- rtl/rtcq_cell.sv -----
module rtcq_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                        clk_i,
  input  rtcq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [rtcq_pkg::TIME_W-1:0] new_time_i,
  input  logic [TAG_BITS-1:0]         new_tag_i,
  input  logic                        prev_shift_i,
  input  logic [rtcq_pkg::TIME_W-1:0] prev_time_i,
  input  logic [TAG_BITS-1:0]         prev_tag_i,
  input  logic [rtcq_pkg::TIME_W-1:0] next_time_i,
  input  logic [TAG_BITS-1:0]         next_tag_i,
  output logic                        shift_o,
  output logic [rtcq_pkg::TIME_W-1:0] time_o,
  output logic [TAG_BITS-1:0]         tag_o
);
  import rtcq_pkg::*;

  logic [TIME_W-1:0]   time_q, time_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                write;

  // Strictly later entries move back, so equal times keep arrival order
  assign shift_o = ctrl_i.occupied && (time_q > new_time_i);
  assign write   = ctrl_i.ins && (shift_o || ctrl_i.at_tail);

  always_comb begin
    time_d = time_q;
    tag_d  = tag_q;
    if (ctrl_i.pop) begin
      time_d = next_time_i;
      tag_d  = next_tag_i;
    end else if (write) begin
      if (prev_shift_i) begin
        time_d = prev_time_i;
        tag_d  = prev_tag_i;
      end else begin
        time_d = new_time_i;
        tag_d  = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    tag_q  <= tag_d;
  end

  assign time_o = time_q;
  assign tag_o  = tag_q;

endmodule

// ----- rtl/rtcq_queue.sv -----
module rtcq_queue #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ins_i,
  input  logic                        pop_i,
  input  logic [rtcq_pkg::TIME_W-1:0] new_time_i,
  input  logic [TAG_BITS-1:0]         new_tag_i,
  output logic [CNT_W-1:0]            count_o,
  output logic [rtcq_pkg::TIME_W-1:0] head_time_o,
  output logic [TAG_BITS-1:0]         head_tag_o
);
  import rtcq_pkg::*;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [TIME_W-1:0]   cell_time [DEPTH];
  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  logic                cell_shift [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic                prev_shift;
    logic [TIME_W-1:0]   prev_time, next_time;
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    assign ctrl.ins      = ins_i;
    assign ctrl.pop      = pop_i;
    assign ctrl.occupied = (CNT_W'(i) < count_q);
    assign ctrl.at_tail  = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      assign prev_shift = 1'b0;
      assign prev_time  = new_time_i;
      assign prev_tag   = new_tag_i;
    end else begin : g_mid
      assign prev_shift = cell_shift[i-1];
      assign prev_time  = cell_time[i-1];
      assign prev_tag   = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_time = cell_time[i];
      assign next_tag  = cell_tag[i];
    end else begin : g_inner
      assign next_time = cell_time[i+1];
      assign next_tag  = cell_tag[i+1];
    end

    rtcq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_time_i  (new_time_i),
      .new_tag_i   (new_tag_i),
      .prev_shift_i(prev_shift),
      .prev_time_i (prev_time),
      .prev_tag_i  (prev_tag),
      .next_time_i (next_time),
      .next_tag_i  (next_tag),
      .shift_o     (cell_shift[i]),
      .time_o      (cell_time[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o     = count_q;
  assign head_time_o = cell_time[0];
  assign head_tag_o  = cell_tag[0];

endmodule

// ----- rtl/two_class_release_time_queue.sv -----
// Pipeline: each item passes the operand register, then the result register; the result
// register loads only when the output is not stalled, so a stall can hold an item back.
// Throughput: one item per cycle while results drain; an insert or a head removal updates
// the whole row of cells together, each cell comparing against the new time in parallel.
// Reset: clears both fill counts and the pipeline valid flags; cell contents stay undefined.
module two_class_release_time_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic                           premium_i,
  input  logic [rtcq_pkg::TIME_W-1:0]    release_time_i,
  input  logic [rtcq_pkg::OUT_TAG_W-1:0] item_tag_i,
  input  logic [rtcq_pkg::TIME_W-1:0]    current_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rtcq_pkg::STATUS_W-1:0]  status_o,
  output logic [rtcq_pkg::OUT_TAG_W-1:0] out_tag_o,
  output logic [rtcq_pkg::TIME_W-1:0]    out_release_time_o,
  output logic                           from_premium_o
);
  import rtcq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operand stage
  logic                 op_valid_q;
  logic                 op_mode_q, op_prem_q;
  logic [TIME_W-1:0]    op_rtime_q, op_now_q;
  logic [OUT_TAG_W-1:0] op_tag_q;
  logic                 op_fire, in_accept;

  // Result stage
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [OUT_TAG_W-1:0] out_tag_q, out_tag_d;
  logic [TIME_W-1:0]    out_time_q, out_time_d;
  logic                 out_prem_q, out_prem_d;

  logic [TAG_BITS-1:0]  new_tag;
  logic [CNT_W-1:0]     p_cnt, n_cnt;
  logic [TIME_W-1:0]    p_head_time, n_head_time;
  logic [TAG_BITS-1:0]  p_head_tag, n_head_tag;
  logic [OUT_TAG_W-1:0] p_head_tag_out, n_head_tag_out;
  logic                 p_full, n_full, p_due, n_due;
  logic                 p_ins, n_ins, p_pop, n_pop;
  logic                 is_store, is_req;

  assign op_fire    = op_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = op_valid_q && !op_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  if (TAG_BITS <= OUT_TAG_W) begin : g_narrow_tag
    assign new_tag        = op_tag_q[TAG_BITS-1:0];
    assign p_head_tag_out = OUT_TAG_W'(p_head_tag);
    assign n_head_tag_out = OUT_TAG_W'(n_head_tag);
  end else begin : g_wide_tag
    assign new_tag        = TAG_BITS'(op_tag_q);
    assign p_head_tag_out = p_head_tag[OUT_TAG_W-1:0];
    assign n_head_tag_out = n_head_tag[OUT_TAG_W-1:0];
  end

  assign p_full = (p_cnt == CNT_W'(QUEUE_DEPTH));
  assign n_full = (n_cnt == CNT_W'(QUEUE_DEPTH));
  assign p_due  = (p_cnt != '0) && (p_head_time <= op_now_q);
  assign n_due  = (n_cnt != '0) && (n_head_time <= op_now_q);

  assign is_store = op_fire && (op_mode_q == MODE_STORE);
  assign is_req   = op_fire && (op_mode_q == MODE_REQUEST);
  assign p_ins    = is_store && op_prem_q && !p_full;
  assign n_ins    = is_store && !op_prem_q && !n_full;
  assign p_pop    = is_req && p_due;
  assign n_pop    = is_req && !p_due && n_due;

  rtcq_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS),
    .CNT_W   (CNT_W)
  ) u_premium (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ins_i      (p_ins),
    .pop_i      (p_pop),
    .new_time_i (op_rtime_q),
    .new_tag_i  (new_tag),
    .count_o    (p_cnt),
    .head_time_o(p_head_time),
    .head_tag_o (p_head_tag)
  );

  rtcq_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS),
    .CNT_W   (CNT_W)
  ) u_normal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ins_i      (n_ins),
    .pop_i      (n_pop),
    .new_time_i (op_rtime_q),
    .new_tag_i  (new_tag),
    .count_o    (n_cnt),
    .head_time_o(n_head_time),
    .head_tag_o (n_head_tag)
  );

  always_comb begin
    out_status_d = STAT_NONE_DUE;
    out_tag_d    = '0;
    out_time_d   = '0;
    out_prem_d   = 1'b0;
    if (op_mode_q == MODE_STORE) begin
      out_status_d = (op_prem_q ? p_full : n_full) ? STAT_FULL : STAT_STORED;
    end else if (p_due) begin
      out_status_d = STAT_RELEASED;
      out_tag_d    = p_head_tag_out;
      out_time_d   = p_head_time;
      out_prem_d   = 1'b1;
    end else if (n_due) begin
      out_status_d = STAT_RELEASED;
      out_tag_d    = n_head_tag_out;
      out_time_d   = n_head_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        op_valid_q <= 1'b1;
      end else if (op_fire) begin
        op_valid_q <= 1'b0;
      end
      if (op_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: operand fields load on accept, result fields on fire; hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_mode_q  <= mode_i;
      op_prem_q  <= premium_i;
      op_rtime_q <= release_time_i;
      op_tag_q   <= item_tag_i;
      op_now_q   <= current_time_i;
    end
    if (op_fire) begin
      out_status_q <= out_status_d;
      out_tag_q    <= out_tag_d;
      out_time_q   <= out_time_d;
      out_prem_q   <= out_prem_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign out_tag_o          = out_tag_q;
  assign out_release_time_o = out_time_q;
  assign from_premium_o     = out_prem_q;

  a_prem_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_cnt <= CNT_W'(QUEUE_DEPTH)) && (n_cnt <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue fill count above depth");

  a_prem_store_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_ins |=> (p_cnt == $past(p_cnt) + CNT_W'(1)))
    else $error("premium store did not grow the queue");

  a_prem_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_req && p_due) |=> (out_valid_q && (out_status_q == STAT_RELEASED) && out_prem_q))
    else $error("due premium head not released first");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != STAT_RELEASED))
      |-> ((out_tag_q == '0) && (out_time_q == '0) && !out_prem_q))
    else $error("non-release result carries item fields");

endmodule
